// ----- src/trae_pkg.sv -----
// Package with the shared types, codes and reset values of the TFTP receive ACK engine.
package trae_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FILE_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES   = 2'd3;

  localparam logic [15:0] RST_BLOCK_SIZE    = 16'd512;
  localparam logic [31:0] RST_MAX_FILE_SIZE = 32'hFFFF_FFFF;
  localparam logic [7:0]  RST_TIMEOUT_TICKS = 8'd5;
  localparam logic [7:0]  RST_MAX_RETRIES   = 8'd5;

  localparam logic [2:0] REQ_START  = 3'd0;
  localparam logic [2:0] REQ_DATA   = 3'd1;
  localparam logic [2:0] REQ_ACK    = 3'd2;
  localparam logic [2:0] REQ_ERRPKT = 3'd3;
  localparam logic [2:0] REQ_TICK   = 3'd4;

  localparam logic [1:0] ERR_ILLEGAL  = 2'd0;
  localparam logic [1:0] ERR_DISKFULL = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT  = 2'd2;

  localparam logic [7:0] TICK_MAX = 8'd255;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_XFER = 2'd1,
    ST_DONE = 2'd2,
    ST_ERR  = 2'd3
  } link_state_t;

  typedef struct packed {
    logic [15:0] block_size;
    logic [31:0] max_file_size;
    logic [7:0]  timeout_ticks;
    logic [7:0]  max_retries;
  } trae_cfg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] block_num;
    logic [15:0] payload_len;
    logic [31:0] tsize;
  } trae_item_t;

  typedef struct packed {
    link_state_t link_state;
    logic [15:0] last_block;
    logic [31:0] byte_total;
    logic [31:0] size_limit_adv;
    logic [7:0]  retry_count;
    logic [7:0]  idle_ticks;
    logic        waiting;
  } trae_state_t;

  typedef struct packed {
    logic        send_ack;
    logic [15:0] ack_block;
    logic        send_error;
    logic [1:0]  error_kind;
    logic [1:0]  conn_state;
    logic [31:0] bytes_received;
  } trae_result_t;

endpackage

// ----- src/trae_step.sv -----
// Combinational step logic: next connection state and the result for one item.
module trae_step (
  input  trae_pkg::trae_cfg_t    cfg,
  input  trae_pkg::trae_state_t  st,
  input  trae_pkg::trae_item_t   item,
  output trae_pkg::trae_state_t  st_nxt,
  output trae_pkg::trae_result_t res
);

  logic                  start_bad;
  logic                  data_dup;
  logic                  data_ooo;
  logic [32:0]           sum;
  logic                  over;
  logic                  short_blk;
  logic [7:0]            tick_inc;
  logic                  tick_fire;
  logic                  retry_exh;
  logic                  tick_act;
  trae_pkg::link_state_t link_state_nxt;
  trae_pkg::trae_state_t body;
  logic                  ack;
  logic [15:0]           ack_blk;
  logic                  err;
  logic [1:0]            err_kind;

  assign start_bad = (item.tsize != 32'd0) && (item.tsize > cfg.max_file_size);
  assign data_dup  = item.block_num <= st.last_block;
  assign data_ooo  = {1'b0, item.block_num} != ({1'b0, st.last_block} + 17'd1);
  assign sum       = {1'b0, st.byte_total} + {17'd0, item.payload_len};
  assign over      = (sum > {1'b0, cfg.max_file_size}) ||
                     ((st.size_limit_adv != 32'd0) && (sum > {1'b0, st.size_limit_adv}));
  assign short_blk = item.payload_len < cfg.block_size;
  assign tick_inc  = (st.idle_ticks == trae_pkg::TICK_MAX) ? trae_pkg::TICK_MAX
                                                           : st.idle_ticks + 8'd1;
  assign tick_fire = !(tick_inc < cfg.timeout_ticks);
  assign retry_exh = st.retry_count >= cfg.max_retries;
  assign tick_act  = (st.link_state == trae_pkg::ST_XFER) && st.waiting;

  always_comb begin
    link_state_nxt = st.link_state;
    unique case (item.req_type)
      trae_pkg::REQ_START: begin
        link_state_nxt = start_bad ? trae_pkg::ST_ERR : trae_pkg::ST_XFER;
      end
      trae_pkg::REQ_DATA: begin
        priority if (st.link_state == trae_pkg::ST_IDLE) begin
          link_state_nxt = trae_pkg::ST_ERR;
        end else if (st.link_state == trae_pkg::ST_XFER && !data_dup && !data_ooo) begin
          if (over) begin
            link_state_nxt = trae_pkg::ST_ERR;
          end else if (short_blk) begin
            link_state_nxt = trae_pkg::ST_DONE;
          end
        end else begin
          link_state_nxt = st.link_state;
        end
      end
      trae_pkg::REQ_ACK: begin
        if (st.link_state == trae_pkg::ST_IDLE || st.link_state == trae_pkg::ST_XFER) begin
          link_state_nxt = trae_pkg::ST_ERR;
        end
      end
      trae_pkg::REQ_ERRPKT: begin
        link_state_nxt = trae_pkg::ST_ERR;
      end
      trae_pkg::REQ_TICK: begin
        if (tick_act && tick_fire && retry_exh) begin
          link_state_nxt = trae_pkg::ST_ERR;
        end
      end
      default: begin
        link_state_nxt = st.link_state;
      end
    endcase
  end

  always_comb begin
    body     = st;
    ack      = 1'b0;
    ack_blk  = 16'd0;
    err      = 1'b0;
    err_kind = trae_pkg::ERR_ILLEGAL;
    unique case (item.req_type)
      trae_pkg::REQ_START: begin
        if (start_bad) begin
          err          = 1'b1;
          err_kind     = trae_pkg::ERR_DISKFULL;
          body.waiting = 1'b0;
        end else begin
          body.last_block     = 16'd0;
          body.byte_total     = 32'd0;
          body.size_limit_adv = item.tsize;
          body.retry_count    = 8'd0;
          body.waiting        = 1'b1;
          body.idle_ticks     = 8'd0;
          ack                 = 1'b1;
        end
      end
      trae_pkg::REQ_DATA: begin
        priority if (st.link_state == trae_pkg::ST_IDLE) begin
          err          = 1'b1;
          body.waiting = 1'b0;
        end else if (st.link_state == trae_pkg::ST_ERR) begin
          ack = 1'b0;
        end else if (data_dup) begin
          ack             = 1'b1;
          ack_blk         = item.block_num;
          body.idle_ticks = 8'd0;
        end else if (st.link_state != trae_pkg::ST_XFER) begin
          ack = 1'b0;
        end else if (data_ooo) begin
          ack             = 1'b1;
          ack_blk         = st.last_block;
          body.idle_ticks = 8'd0;
        end else if (over) begin
          err          = 1'b1;
          err_kind     = trae_pkg::ERR_DISKFULL;
          body.waiting = 1'b0;
        end else begin
          body.last_block  = item.block_num;
          body.byte_total  = sum[31:0];
          body.idle_ticks  = 8'd0;
          body.retry_count = 8'd0;
          body.waiting     = !short_blk;
          ack              = 1'b1;
          ack_blk          = item.block_num;
        end
      end
      trae_pkg::REQ_ACK: begin
        if (st.link_state == trae_pkg::ST_IDLE || st.link_state == trae_pkg::ST_XFER) begin
          err          = 1'b1;
          body.waiting = 1'b0;
        end
      end
      trae_pkg::REQ_ERRPKT: begin
        body.waiting = 1'b0;
      end
      trae_pkg::REQ_TICK: begin
        if (tick_act) begin
          body.idle_ticks = tick_inc;
          if (tick_fire) begin
            if (retry_exh) begin
              err          = 1'b1;
              err_kind     = trae_pkg::ERR_TIMEOUT;
              body.waiting = 1'b0;
            end else begin
              body.retry_count = st.retry_count + 8'd1;
              body.idle_ticks  = 8'd0;
              ack              = 1'b1;
              ack_blk          = st.last_block;
            end
          end
        end
      end
      default: begin
        ack = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_nxt            = body;
    st_nxt.link_state = link_state_nxt;
  end

  assign res.send_ack       = ack;
  assign res.ack_block      = ack_blk;
  assign res.send_error     = err;
  assign res.error_kind     = err_kind;
  assign res.conn_state     = link_state_nxt;
  assign res.bytes_received = st_nxt.byte_total;

endmodule

// ----- src/trae_out_reg.sv -----
// Result register that holds one finished item until the receiver takes it.
module trae_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  trae_pkg::trae_result_t res_in,
  input  logic                   out_stall,
  output logic                   out_valid,
  output trae_pkg::trae_result_t res_out
);

  logic                   valid_r;
  logic                   valid_nxt;
  trae_pkg::trae_result_t res_r;

  always_comb begin
    priority if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

// ----- src/tftp_receive_ack_engine_core.sv -----
// Top level of the TFTP receive ACK engine: input register, state, step logic, result register.
//
// Usage: each input item (start, data header, ack, error packet or tick) enters on the
// in_ channel and produces exactly one result item on the out_ channel, carrying the ACK
// and error decisions, the connection state and the byte count after that item.
// An accepted item is held in the input register, processed by the step logic and
// loaded into the result register, which drives out_valid; a receiver stall can hold it
// in the input register. One item per cycle is sustained while the receiver does not
// stall; the state update with its single 33-bit add and its compares is combinational.
// When the receiver stalls, the result register holds its item and the input register
// holds one more; in_stall rises only when both are full and out_stall is high.
// Configuration writes on the cfg_ port are registered; the user must make them only
// while no item is in flight, and the block itself does not enforce this.
// Reset (rst_n low, synchronous) empties both registers, sets the connection to idle,
// clears the counters and restores the register defaults: block size 512, no file
// size limit, five ticks per timeout and five retries.
module tftp_receive_ack_engine_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         in_req_type,
  input  logic [15:0]                        in_block_num,
  input  logic [15:0]                        in_payload_len,
  input  logic [31:0]                        in_tsize,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_send_ack,
  output logic [15:0]                        out_ack_block,
  output logic                               out_send_error,
  output logic [1:0]                         out_error_kind,
  output logic [1:0]                         out_conn_state,
  output logic [31:0]                        out_bytes_received,
  input  logic                               cfg_we,
  input  logic [trae_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trae_pkg::CFG_DATA_W-1:0]    cfg_data
);

  trae_pkg::trae_cfg_t    cfg_r;
  trae_pkg::trae_state_t  st_r;
  trae_pkg::trae_state_t  st_nxt;
  trae_pkg::trae_item_t   item_r;
  logic                   in_valid_r;
  logic                   load_out;
  trae_pkg::trae_result_t res;
  trae_pkg::trae_result_t res_q;

  assign load_out = in_valid_r && (!out_valid || !out_stall);
  assign in_stall = in_valid_r && !load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_size    <= trae_pkg::RST_BLOCK_SIZE;
      cfg_r.max_file_size <= trae_pkg::RST_MAX_FILE_SIZE;
      cfg_r.timeout_ticks <= trae_pkg::RST_TIMEOUT_TICKS;
      cfg_r.max_retries   <= trae_pkg::RST_MAX_RETRIES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        trae_pkg::CFG_BLOCK_SIZE:    cfg_r.block_size    <= cfg_data[15:0];
        trae_pkg::CFG_MAX_FILE_SIZE: cfg_r.max_file_size <= cfg_data[31:0];
        trae_pkg::CFG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_data[7:0];
        trae_pkg::CFG_MAX_RETRIES:   cfg_r.max_retries   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.req_type    <= in_req_type;
      item_r.block_num   <= in_block_num;
      item_r.payload_len <= in_payload_len;
      item_r.tsize       <= in_tsize;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.link_state     <= trae_pkg::ST_IDLE;
      st_r.last_block     <= 16'd0;
      st_r.byte_total     <= 32'd0;
      st_r.size_limit_adv <= 32'd0;
      st_r.retry_count    <= 8'd0;
      st_r.idle_ticks     <= 8'd0;
      st_r.waiting        <= 1'b0;
    end else if (load_out) begin
      st_r <= st_nxt;
    end
  end

  trae_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  trae_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load_out),
    .res_in    (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  assign out_send_ack       = res_q.send_ack;
  assign out_ack_block      = res_q.ack_block;
  assign out_send_error     = res_q.send_error;
  assign out_error_kind     = res_q.error_kind;
  assign out_conn_state     = res_q.conn_state;
  assign out_bytes_received = res_q.bytes_received;

endmodule

// ----- src/trae_checker.sv -----
// Port-level checker for the TFTP receive ACK engine, bound to the top level.
module trae_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_send_ack,
  input logic [15:0]                     out_ack_block,
  input logic                            out_send_error,
  input logic [1:0]                      out_error_kind,
  input logic [1:0]                      out_conn_state,
  input logic [31:0]                     out_bytes_received
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_send_ack) &&
      $stable(out_ack_block) && $stable(out_send_error) && $stable(out_error_kind) &&
      $stable(out_conn_state) && $stable(out_bytes_received))
    else $error("Stalled result item changed.");

  a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_send_ack |-> out_ack_block == 16'd0)
    else $error("ACK block number set without an ACK.");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_send_error |-> out_error_kind == trae_pkg::ERR_ILLEGAL)
    else $error("Error kind set without an error.");

  a_err_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_send_error |-> out_conn_state == trae_pkg::ST_ERR &&
      !out_send_ack)
    else $error("Error item does not report the error state.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

endmodule

bind tftp_receive_ack_engine_core trae_checker u_trae_checker (.*);

// ----- verif/trae_ack_checker.sv -----
// Checker that predicts and compares every result item of the TFTP receive ACK engine.
`timescale 1ns / 100ps

module trae_ack_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [2:0]                      in_req_type,
  input  logic [15:0]                     in_block_num,
  input  logic [15:0]                     in_payload_len,
  input  logic [31:0]                     in_tsize,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            out_send_ack,
  input  logic [15:0]                     out_ack_block,
  input  logic                            out_send_error,
  input  logic [1:0]                      out_error_kind,
  input  logic [1:0]                      out_conn_state,
  input  logic [31:0]                     out_bytes_received,
  input  logic                            cfg_we,
  input  logic [trae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trae_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending_count
);

  logic [15:0] blk_size_cfg;
  logic [31:0] file_limit_cfg;
  logic [7:0]  timeout_cfg;
  logic [7:0]  retry_limit_cfg;

  trae_pkg::link_state_t xfer_state;
  logic [15:0] acked_block;
  logic [31:0] byte_sum;
  logic [31:0] advertised_size;
  logic [7:0]  resend_count;
  logic [7:0]  quiet_ticks;
  logic        awaiting_block;

  trae_pkg::trae_result_t step_out;
  trae_pkg::trae_result_t expected_results[$];
  int                     mismatches;

  function void send_ack_for(logic [15:0] blk);
    step_out.send_ack  = 1'b1;
    step_out.ack_block = blk;
    quiet_ticks        = '0;
  endfunction

  function void abort_transfer(logic [1:0] kind);
    step_out.send_error = 1'b1;
    step_out.error_kind = kind;
    xfer_state          = trae_pkg::ST_ERR;
    awaiting_block      = 1'b0;
  endfunction

  function automatic trae_pkg::trae_result_t advance_transfer(trae_pkg::trae_item_t it);
    logic [32:0] sum;
    step_out = '0;
    case (it.req_type)
      trae_pkg::REQ_START: begin
        if (it.tsize != 0 && it.tsize > file_limit_cfg) begin
          abort_transfer(trae_pkg::ERR_DISKFULL);
        end else begin
          acked_block     = '0;
          byte_sum        = '0;
          advertised_size = it.tsize;
          resend_count    = '0;
          xfer_state      = trae_pkg::ST_XFER;
          awaiting_block  = 1'b1;
          send_ack_for(16'd0);
        end
      end
      trae_pkg::REQ_DATA: begin
        if (xfer_state == trae_pkg::ST_IDLE) begin
          abort_transfer(trae_pkg::ERR_ILLEGAL);
        end else if (xfer_state != trae_pkg::ST_ERR) begin
          if (it.block_num <= acked_block) begin
            send_ack_for(it.block_num);
          end else if (xfer_state == trae_pkg::ST_XFER) begin
            if (it.block_num != acked_block + 16'd1) begin
              send_ack_for(acked_block);
            end else begin
              sum = {1'b0, byte_sum} + {17'b0, it.payload_len};
              if (sum > {1'b0, file_limit_cfg} ||
                  (advertised_size != 0 && sum > {1'b0, advertised_size})) begin
                abort_transfer(trae_pkg::ERR_DISKFULL);
              end else begin
                acked_block    = it.block_num;
                byte_sum       = sum[31:0];
                send_ack_for(it.block_num);
                resend_count   = '0;
                awaiting_block = 1'b1;
                if (it.payload_len < blk_size_cfg) begin
                  awaiting_block = 1'b0;
                  xfer_state     = trae_pkg::ST_DONE;
                end
              end
            end
          end
        end
      end
      trae_pkg::REQ_ACK: begin
        if (xfer_state == trae_pkg::ST_IDLE || xfer_state == trae_pkg::ST_XFER)
          abort_transfer(trae_pkg::ERR_ILLEGAL);
      end
      trae_pkg::REQ_ERRPKT: begin
        xfer_state     = trae_pkg::ST_ERR;
        awaiting_block = 1'b0;
      end
      trae_pkg::REQ_TICK: begin
        if (xfer_state == trae_pkg::ST_XFER && awaiting_block) begin
          if (quiet_ticks != trae_pkg::TICK_MAX) quiet_ticks = quiet_ticks + 8'd1;
          if (quiet_ticks >= timeout_cfg) begin
            if (resend_count >= retry_limit_cfg) begin
              abort_transfer(trae_pkg::ERR_TIMEOUT);
            end else begin
              resend_count = resend_count + 8'd1;
              send_ack_for(acked_block);
            end
          end
        end
      end
      default: ;
    endcase
    step_out.conn_state     = xfer_state;
    step_out.bytes_received = byte_sum;
    return step_out;
  endfunction

  function void report(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch in %s: expected %0h, got %0h", what, want, got);
  endfunction

  always @(posedge clk) begin
    trae_pkg::trae_item_t   item;
    trae_pkg::trae_result_t exp_res;
    if (!rst_n) begin
      blk_size_cfg    = trae_pkg::RST_BLOCK_SIZE;
      file_limit_cfg  = trae_pkg::RST_MAX_FILE_SIZE;
      timeout_cfg     = trae_pkg::RST_TIMEOUT_TICKS;
      retry_limit_cfg = trae_pkg::RST_MAX_RETRIES;
      xfer_state      = trae_pkg::ST_IDLE;
      acked_block     = '0;
      byte_sum        = '0;
      advertised_size = '0;
      resend_count    = '0;
      quiet_ticks     = '0;
      awaiting_block  = 1'b0;
      expected_results.delete();
      mismatches      = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result item with no expected result waiting");
        end else begin
          exp_res = expected_results.pop_front();
          if (out_send_ack !== exp_res.send_ack)
            report("send_ack", 32'(exp_res.send_ack), 32'(out_send_ack));
          if (out_ack_block !== exp_res.ack_block)
            report("ack_block", 32'(exp_res.ack_block), 32'(out_ack_block));
          if (out_send_error !== exp_res.send_error)
            report("send_error", 32'(exp_res.send_error), 32'(out_send_error));
          if (out_error_kind !== exp_res.error_kind)
            report("error_kind", 32'(exp_res.error_kind), 32'(out_error_kind));
          if (out_conn_state !== exp_res.conn_state)
            report("conn_state", 32'(exp_res.conn_state), 32'(out_conn_state));
          if (out_bytes_received !== exp_res.bytes_received)
            report("bytes_received", exp_res.bytes_received, out_bytes_received);
        end
      end
      if (in_valid && !in_stall) begin
        item.req_type    = in_req_type;
        item.block_num   = in_block_num;
        item.payload_len = in_payload_len;
        item.tsize       = in_tsize;
        expected_results.insert(expected_results.size(), advance_transfer(item));
      end
      if (cfg_we) begin
        case (cfg_index)
          trae_pkg::CFG_BLOCK_SIZE:    blk_size_cfg    = cfg_data[15:0];
          trae_pkg::CFG_MAX_FILE_SIZE: file_limit_cfg  = cfg_data[31:0];
          trae_pkg::CFG_TIMEOUT_TICKS: timeout_cfg     = cfg_data[7:0];
          trae_pkg::CFG_MAX_RETRIES:   retry_limit_cfg = cfg_data[7:0];
          default: ;
        endcase
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_results.size();
  end

endmodule

// ----- verif/testbench.sv -----
// Top of the testbench: clock, reset, stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 80;
  localparam int PRESSURE_AT    = 700;
  localparam int PHASE_ITEMS    = 250;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [2:0]                      in_req_type;
  logic [15:0]                     in_block_num;
  logic [15:0]                     in_payload_len;
  logic [31:0]                     in_tsize;
  logic                            out_valid;
  logic                            out_stall;
  logic                            out_send_ack;
  logic [15:0]                     out_ack_block;
  logic                            out_send_error;
  logic [1:0]                      out_error_kind;
  logic [1:0]                      out_conn_state;
  logic [31:0]                     out_bytes_received;
  logic                            cfg_we;
  logic [trae_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [trae_pkg::CFG_DATA_W-1:0] cfg_data;

  int          fail_count;
  int          pending_count;
  int          sent_items = 0;
  int          quiet_cycles = 0;
  logic        calm = 1'b0;
  logic        pressure_done = 1'b0;
  logic [15:0] cur_bs = trae_pkg::RST_BLOCK_SIZE;
  logic [7:0]  cur_to = trae_pkg::RST_TIMEOUT_TICKS;
  logic [7:0]  cur_mr = trae_pkg::RST_MAX_RETRIES;

  tftp_receive_ack_engine_core DUT (.*);

  trae_ack_checker CHECK (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_item(input logic [2:0] req, input logic [15:0] blk,
                           input logic [15:0] len, input logic [31:0] ts);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_block_num   <= blk;
    in_payload_len <= len;
    in_tsize       <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_data(input logic [15:0] blk, input logic [15:0] len);
    send_item(trae_pkg::REQ_DATA, blk, len, $urandom);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(trae_pkg::REQ_TICK, 16'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic send_noise();
    send_item(3'($urandom_range(7)), 16'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic write_reg(input logic [trae_pkg::CFG_IDX_W-1:0] idx,
                           input logic [trae_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_transfer();
    int unsigned pick;
    int unsigned nblk;
    int unsigned long_run;
    logic [31:0] ts;
    logic [15:0] len;
    pick = $urandom_range(9);
    if (pick < 6) ts = '0;
    else if (pick < 8) ts = $urandom_range(1, 4 * cur_bs + 100);
    else ts = $urandom;
    send_item(trae_pkg::REQ_START, 16'($urandom), 16'($urandom), ts);
    nblk = $urandom_range(1, 8);
    long_run = cur_to * (cur_mr + 2);
    if (long_run > 60) long_run = 60;
    for (int unsigned b = 1; b <= nblk; b++) begin
      pick = $urandom_range(19);
      if (pick < 3) send_ticks($urandom_range(1, 3));
      else if (pick == 3) send_ticks(long_run);
      else if (pick == 4) send_data(16'($urandom), 16'($urandom));
      else if (pick == 5) send_data(16'(b - 1), cur_bs);
      else if (pick == 6) send_noise();
      if (cur_bs == 0) len = 16'($urandom_range(0, 40));
      else if (b == nblk) len = 16'($urandom_range(0, cur_bs - 1));
      else if ($urandom_range(9) == 0) len = cur_bs + 16'($urandom_range(0, 65535 - cur_bs));
      else len = cur_bs;
      send_data(16'(b), len);
    end
    pick = $urandom_range(9);
    if (pick < 3) send_ticks($urandom_range(1, 3));
    else if (pick == 3) send_data(16'($urandom_range(0, nblk + 2)), cur_bs);
    else if (pick == 4)
      send_item(trae_pkg::REQ_ACK, 16'($urandom), 16'($urandom), $urandom);
    else if (pick == 5)
      send_item(trae_pkg::REQ_ERRPKT, 16'($urandom), 16'($urandom), $urandom);
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressure_done && sent_items >= PRESSURE_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        pressure_done = 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 23);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] bs;
    logic [31:0] mfs;
    logic [7:0]  to;
    logic [7:0]  mr;
    int          goal;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = '0;
    in_block_num   = '0;
    in_payload_len = '0;
    in_tsize       = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_data(16'd1, 16'd10);
    send_item(trae_pkg::REQ_ACK, 16'd0, 16'd0, 32'd0);
    send_item(3'd5, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(3'd7, 16'd0, 16'd0, 32'd0);
    send_item(trae_pkg::REQ_START, 16'd0, 16'd0, 32'd0);
    send_item(trae_pkg::REQ_ACK, 16'd1, 16'd0, 32'd0);
    send_data(16'd1, 16'd512);
    send_item(trae_pkg::REQ_START, 16'd0, 16'd0, 32'hFFFF_FFFF);
    send_data(16'd1, 16'd65464);
    send_data(16'd1, 16'd512);
    send_data(16'hFFFF, 16'd512);
    send_data(16'd0, 16'd0);
    send_ticks(5);
    send_data(16'd2, 16'd0);
    send_data(16'd1, 16'd512);
    send_data(16'd3, 16'd512);
    send_item(trae_pkg::REQ_ACK, 16'd2, 16'd0, 32'd0);
    send_item(trae_pkg::REQ_ERRPKT, 16'd0, 16'd0, 32'd0);
    send_item(trae_pkg::REQ_START, 16'd0, 16'd0, 32'd100);
    send_data(16'd1, 16'd512);

    for (int p = 1; p <= 7; p++) begin
      settle();
      case (p)
        1: begin bs = 16'd8;     mfs = 32'd300;         to = 8'd1;   mr = 8'd0;   end
        2: begin bs = 16'd65464; mfs = 32'hFFFF_FFFF;   to = 8'd255; mr = 8'd255; end
        3: begin bs = 16'd0;     mfs = 32'd0;           to = 8'd0;   mr = 8'd2;   end
        4: begin bs = 16'd16;    mfs = 32'd2000;        to = 8'd2;   mr = 8'd3;   end
        default: begin
          bs = 16'($urandom_range(8, 64));
          case ($urandom_range(2))
            0: mfs = $urandom_range(50, 5000);
            1: mfs = 32'hFFFF_FFFF;
            default: mfs = $urandom;
          endcase
          to = 8'($urandom_range(1, 4));
          mr = 8'($urandom_range(0, 4));
        end
      endcase
      write_reg(trae_pkg::CFG_BLOCK_SIZE, {16'd0, bs});
      write_reg(trae_pkg::CFG_MAX_FILE_SIZE, mfs);
      write_reg(trae_pkg::CFG_TIMEOUT_TICKS, {24'd0, to});
      write_reg(trae_pkg::CFG_MAX_RETRIES, {24'd0, mr});
      @(negedge clk);
      cfg_we <= 1'b0;
      cur_bs = bs;
      cur_to = to;
      cur_mr = mr;
      calm = (p == 4);
      goal = sent_items + PHASE_ITEMS;
      while (sent_items < goal) begin
        if ($urandom_range(9) == 0) send_noise();
        else run_transfer();
      end
    end
    calm = 1'b0;
    settle();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
